[design/mrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg
// Types and constants shared by the raster cell combine datapath.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int LANES       = 4;
    localparam int FRAC_BITS   = 16;
    localparam int CELL_W      = 32;
    localparam int OUT_W       = 48;
    localparam int PROD_W      = OUT_W + CELL_W;
    localparam int SUM_W       = CELL_W + $clog2(LANES) + 1;
    localparam int CNT_W       = $clog2(LANES + 1);
    localparam int MODE_W      = 3;
    localparam int LANES_REG_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes on the configuration port.
    localparam int REG_MODE    = 0;
    localparam int REG_LANES   = 1;
    localparam int REG_NODATA0 = 2;
    localparam int CFG_IDX_W   = $clog2(REG_NODATA0 + LANES);

    localparam logic [LANES_REG_W-1:0] LANES_RESET = LANES_REG_W'(4);

    // Mean divider: DIV_STEP quotient bits per stage.
    localparam int DIV_STEP   = 6;
    localparam int DIV_STAGES = (SUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_STAGES * DIV_STEP;

    localparam logic [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_MUL   = 3'd0,
        MODE_MAX   = 3'd1,
        MODE_MIN   = 3'd2,
        MODE_RANGE = 3'd3,
        MODE_MEAN  = 3'd4
    } t_mode;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_lane0;
        logic signed [CELL_W-1:0] cell_lane1;
        logic signed [CELL_W-1:0] cell_lane2;
        logic signed [CELL_W-1:0] cell_lane3;
    } t_cells;

    typedef struct packed {
        logic signed [OUT_W-1:0] combined_value;
        logic                    is_nodata;
        logic                    saturated;
    } t_result;

    typedef logic [LANES-1:0][CELL_W-1:0] t_lanes;

    // Running state handed from one lane cell to the next.
    typedef struct packed {
        logic                     nod;
        logic                     zero;
        logic                     neg;
        logic                     clip;
        logic [OUT_W-1:0]         mag;
        logic signed [CELL_W-1:0] mx;
        logic signed [CELL_W-1:0] mn;
        logic signed [SUM_W-1:0]  sum;
    } t_acc;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [DIV_W-1:0] dvd;
    } t_div;

endpackage

[design/multi_raster_cell_combine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_raster_cell_combine
// Combines co-located raster cells by product, max, min, range or mean,
// with per-lane nodata detection and saturation of the product to Q32.16.
// ----------------------------------------------------------------------------
// Pipeline: each lane cell takes two stages for its split multiply, the mean
// divider takes six bits per stage, and the result is registered before it
// reaches the outputs with its strobe.
// Throughput: one cell transfer per cycle while busy is low; the result receiver cannot stall.
// Reset: synchronous, clears the pipeline valid flags and restores the register
// defaults; busy is high during reset and falls at the first edge that sees it released.
module multi_raster_cell_combine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mrc_pkg::t_cells                i_cells,
    output logic                           o_result_strobe,
    output mrc_pkg::t_result               o_result,
    input  logic                           i_cfg_we,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mrc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mrc_pkg::*;

    localparam int LATENCY = 2 * LANES + DIV_STAGES + 1;

    logic                   r_busy;
    logic [MODE_W-1:0]      r_mode;
    logic [LANES_REG_W-1:0] r_lanes;
    logic [CELL_W-1:0]      r_nodata [LANES];

    logic [CNT_W-1:0]       lanes_used;
    logic                   accept;

    logic                   w_vld  [LANES+1];
    t_acc                   w_acc  [LANES+1];
    t_lanes                 w_vals [LANES+1];

    logic                   w_dvld [DIV_STAGES+1];
    t_acc                   w_dacc [DIV_STAGES+1];
    t_div                   w_div  [DIV_STAGES+1];

    logic [SUM_W-1:0]       sum_mag;
    t_acc                   fin_acc;
    logic [DIV_W-1:0]       quo;
    logic [OUT_W-1:0]       quo_x;
    logic signed [CELL_W:0] rng;
    logic [OUT_W-1:0]       val;
    logic                   sat;
    logic                   nod;
    t_result                n_result;

    logic                   r_strobe;
    t_result                r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_mode  <= MODE_MUL;
            r_lanes <= LANES_RESET;
            for (int k = 0; k < LANES; k++) r_nodata[k] <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_W'(REG_MODE)) r_mode <= i_cfg_data[MODE_W-1:0];
                if (i_cfg_idx == CFG_IDX_W'(REG_LANES)) r_lanes <= i_cfg_data[LANES_REG_W-1:0];
                for (int k = 0; k < LANES; k++) begin
                    if (i_cfg_idx == CFG_IDX_W'(REG_NODATA0 + k)) r_nodata[k] <= i_cfg_data;
                end
            end
        end
    end

    assign busy       = r_busy;
    assign accept     = start && !r_busy;
    assign lanes_used = (r_lanes > LANES_REG_W'(LANES)) ? CNT_W'(LANES) : CNT_W'(r_lanes);

    assign w_vld[0]  = accept;
    assign w_acc[0]  = '0;
    assign w_vals[0] = {i_cells.cell_lane3, i_cells.cell_lane2,
                        i_cells.cell_lane1, i_cells.cell_lane0};

    for (genvar g = 0; g < LANES; g++) begin : g_cell
        mrc_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_vld        (w_vld[g]),
            .i_acc        (w_acc[g]),
            .i_vals       (w_vals[g]),
            .i_nodata     (r_nodata[g]),
            .i_lanes_used (lanes_used),
            .o_vld        (w_vld[g+1]),
            .o_acc        (w_acc[g+1]),
            .o_vals       (w_vals[g+1])
        );
    end

    // Mean rounding: add half the count before dividing the magnitude.
    always_comb begin
        sum_mag = w_acc[LANES].sum[SUM_W-1] ? (~w_acc[LANES].sum + 1'b1) : w_acc[LANES].sum;
    end

    assign w_dvld[0]    = w_vld[LANES];
    assign w_dacc[0]    = w_acc[LANES];
    assign w_div[0].rem = '0;
    assign w_div[0].dvd = DIV_W'(sum_mag) + DIV_W'(lanes_used >> 1);

    for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
        mrc_div_step u_div (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_vld        (w_dvld[d]),
            .i_acc        (w_dacc[d]),
            .i_div        (w_div[d]),
            .i_lanes_used (lanes_used),
            .o_vld        (w_dvld[d+1]),
            .o_acc        (w_dacc[d+1]),
            .o_div        (w_div[d+1])
        );
    end

    always_comb begin
        fin_acc = w_dacc[DIV_STAGES];
        quo     = w_div[DIV_STAGES].dvd;
        quo_x   = OUT_W'(quo);
        rng     = {fin_acc.mx[CELL_W-1], fin_acc.mx} - {fin_acc.mn[CELL_W-1], fin_acc.mn};
        nod     = fin_acc.nod || (lanes_used == '0) || (r_mode > MODE_MEAN);
        val     = '0;
        sat     = 1'b0;
        case (r_mode)
            MODE_MUL: begin
                // A zero lane forces a zero product, whatever clamped earlier.
                if (!fin_acc.zero) begin
                    val = fin_acc.neg ? (~fin_acc.mag + 1'b1) : fin_acc.mag;
                    sat = fin_acc.clip;
                end
            end
            MODE_MAX:   val = OUT_W'(fin_acc.mx);
            MODE_MIN:   val = OUT_W'(fin_acc.mn);
            MODE_RANGE: val = OUT_W'(rng);
            MODE_MEAN:  val = fin_acc.sum[SUM_W-1] ? (~quo_x + 1'b1) : quo_x;
            default:    val = '0;
        endcase
        if (nod) begin
            val = '0;
            sat = 1'b0;
        end
        n_result.combined_value = val;
        n_result.is_nodata      = nod;
        n_result.saturated      = sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_dvld[DIV_STAGES];
        end
        r_result <= n_result;
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_result_strobe)
        else $error("accepted cell produced no result at the expected cycle");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(accept, LATENCY))
        else $error("result strobe without a matching start transfer");

    a_nodata_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.is_nodata) |->
            (o_result.combined_value == '0 && !o_result.saturated))
        else $error("nodata result carries a value or saturation");

    a_sat_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.saturated) |-> (r_mode == MODE_MUL))
        else $error("saturation outside multiply mode");

endmodule

[design/mrc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_cell
// One lane of the combine chain: nodata check, min/max/sum update and, past
// lane 0, one rounded, clamped magnitude multiply split over two register stages.
// ----------------------------------------------------------------------------
module mrc_cell #(
    parameter int IDX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  mrc_pkg::t_acc                i_acc,
    input  mrc_pkg::t_lanes              i_vals,
    input  logic [mrc_pkg::CELL_W-1:0]   i_nodata,
    input  logic [mrc_pkg::CNT_W-1:0]    i_lanes_used,
    output logic                         o_vld,
    output mrc_pkg::t_acc                o_acc,
    output mrc_pkg::t_lanes              o_vals
);
    import mrc_pkg::*;

    localparam logic [PROD_W-1:0] RND =
        PROD_W'(FRAC_BITS > 0) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0);

    logic                     used;
    logic signed [CELL_W-1:0] v;
    logic [CELL_W-1:0]        b;
    t_acc                     n_acc_a;
    logic                     n_mul;
    logic [2*CELL_W-1:0]      n_plo;
    logic [OUT_W-1:0]         n_pmid;

    logic                     r_vld_a;
    t_acc                     r_acc_a;
    logic                     r_mul;
    logic [2*CELL_W-1:0]      r_plo;
    logic [OUT_W-1:0]         r_pmid;
    t_lanes                   r_vals_a;

    logic [PROD_W-1:0]        full;
    logic [PROD_W-1:0]        shifted;
    logic [OUT_W-1:0]         lim;
    t_acc                     n_acc_b;

    logic                     r_vld_b;
    t_acc                     r_acc_b;
    t_lanes                   r_vals_b;

    // Stage A: lane update and partial products of the running magnitude.
    always_comb begin
        used    = CNT_W'(IDX) < i_lanes_used;
        v       = i_vals[IDX];
        b       = v[CELL_W-1] ? (~i_vals[IDX] + 1'b1) : i_vals[IDX];
        n_acc_a = i_acc;
        n_mul   = 1'b0;
        if (used) begin
            if (i_vals[IDX] == i_nodata) n_acc_a.nod = 1'b1;
            if (v == '0) n_acc_a.zero = 1'b1;
            n_acc_a.sum = i_acc.sum + SUM_W'(v);
            if (IDX == 0) begin
                n_acc_a.mx  = v;
                n_acc_a.mn  = v;
                n_acc_a.mag = OUT_W'(b);
                n_acc_a.neg = v[CELL_W-1];
            end else begin
                if (v > i_acc.mx) n_acc_a.mx = v;
                if (v < i_acc.mn) n_acc_a.mn = v;
                n_acc_a.neg = i_acc.neg ^ v[CELL_W-1];
                n_mul       = 1'b1;
            end
        end
        n_plo  = i_acc.mag[CELL_W-1:0] * b;
        n_pmid = i_acc.mag[OUT_W-1:CELL_W] * b;
    end

    // Stage B: join the partial products, round, scale and clamp.
    always_comb begin
        full    = PROD_W'(r_plo) + {r_pmid, CELL_W'(0)} + RND;
        shifted = full >> FRAC_BITS;
        lim     = r_acc_a.neg ? NEG_LIM : POS_LIM;
        n_acc_b = r_acc_a;
        if (r_mul) begin
            if (shifted > PROD_W'(lim)) begin
                n_acc_b.mag  = lim;
                n_acc_b.clip = 1'b1;
            end else begin
                n_acc_b.mag = shifted[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
        r_acc_a  <= n_acc_a;
        r_mul    <= n_mul;
        r_plo    <= n_plo;
        r_pmid   <= n_pmid;
        r_vals_a <= i_vals;
        r_acc_b  <= n_acc_b;
        r_vals_b <= r_vals_a;
    end

    assign o_vld  = r_vld_b;
    assign o_acc  = r_acc_b;
    assign o_vals = r_vals_b;

endmodule

[design/mrc_div_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_div_step
// One stage of the restoring divider for the mean: DIV_STEP quotient bits of
// the rounded sum magnitude divided by the lane count.
// ----------------------------------------------------------------------------
module mrc_div_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  mrc_pkg::t_acc             i_acc,
    input  mrc_pkg::t_div             i_div,
    input  logic [mrc_pkg::CNT_W-1:0] i_lanes_used,
    output logic                      o_vld,
    output mrc_pkg::t_acc             o_acc,
    output mrc_pkg::t_div             o_div
);
    import mrc_pkg::*;

    logic [CNT_W:0] rem2;
    t_div           n_div;

    logic           r_vld;
    t_acc           r_acc;
    t_div           r_div;

    // The dividend shifts out at the top while quotient bits enter below.
    always_comb begin
        n_div = i_div;
        rem2  = '0;
        for (int j = 0; j < DIV_STEP; j++) begin
            rem2      = {n_div.rem, n_div.dvd[DIV_W-1]};
            n_div.dvd = {n_div.dvd[DIV_W-2:0], 1'b0};
            if (rem2 >= {1'b0, i_lanes_used}) begin
                n_div.rem    = CNT_W'(rem2 - {1'b0, i_lanes_used});
                n_div.dvd[0] = 1'b1;
            end else begin
                n_div.rem = rem2[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_acc <= i_acc;
        r_div <= n_div;
    end

    assign o_vld = r_vld;
    assign o_acc = r_acc;
    assign o_div = r_div;

endmodule

[dv/multi_raster_cell_combine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_raster_cell_combine_test
// Self-checking bench for the raster cell combine block. A short table of
// directed cells covers the mode, lane count and nodata corners, some with
// hand-written results. Random phases follow, each under a new register
// setting. Cells without a hand-written result are scored against an in-bench predictor.
// ----------------------------------------------------------------------------
module multi_raster_cell_combine_test;

    import mrc_pkg::*;

    localparam int PHASES      = 13;
    localparam int PHASE_ITEMS = 87;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    localparam logic [CELL_W-1:0] C_ONE  = 32'h0001_0000;
    localparam logic [CELL_W-1:0] C_MAX  = 32'h7FFF_FFFF;
    localparam logic [CELL_W-1:0] C_MIN  = 32'h8000_0000;
    localparam logic [CELL_W-1:0] C_MONE = 32'hFFFF_FFFF;

    localparam logic [MODE_W-1:0] MODE_UNKNOWN_LO = MODE_W'(MODE_MEAN + 1);
    localparam logic [MODE_W-1:0] MODE_UNKNOWN_HI = '1;

    // Nodata values used by the directed rows, lane 3 first.
    localparam t_lanes ND_DIR = {32'hA5A5_0003, 32'hA5A5_0002, 32'hA5A5_0001, 32'hA5A5_0000};

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [LANES_REG_W-1:0] lanes;
        logic                   nd_on;
        t_cells                 cells;
        logic                   typed;
        t_result                want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_cells                i_cells;
    logic                  o_result_strobe;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Hand-written result riding along with the cell currently offered.
    logic    pin_on;
    t_result pin_want;

    // Predictor copy of the register file.
    logic [MODE_W-1:0]      pm_mode;
    logic [LANES_REG_W-1:0] pm_lanes;
    logic [CELL_W-1:0]      pm_nodata [LANES];

    t_result due_results [$];
    t_result next_due;
    t_row    plan [$];
    t_lanes  nodata_now;
    logic    calm;

    int cells_sent;
    int results_seen;
    int mismatches;
    int cfg_writes;
    int nodata_seen;
    int clipped_seen;
    int cycles;

    multi_raster_cell_combine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cells         (i_cells),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycles, results_seen, cells_sent);
            $display("[multi_raster_cell_combine] ERROR");
            $finish;
        end
    end

    // Expected result of one cell under the current predictor registers.
    function automatic t_result combine_cells(input t_cells c);
        logic signed [CELL_W-1:0] v [LANES];
        logic signed [63:0]       acc, mx, mn, sum;
        logic [63:0]              mag, b, lim, m, q;
        logic [127:0]             prod;
        logic                     nod, clip, neg, any_zero;
        int                       n;
        t_result                  r;
        v[0] = c.cell_lane0;
        v[1] = c.cell_lane1;
        v[2] = c.cell_lane2;
        v[3] = c.cell_lane3;
        n = (pm_lanes > LANES) ? LANES : int'(pm_lanes);
        nod = (n == 0) || (pm_mode > MODE_MEAN);
        clip = 1'b0;
        acc = '0;
        for (int i = 0; i < n; i++) begin
            if (v[i] == pm_nodata[i]) nod = 1'b1;
        end
        if (!nod) begin
            case (pm_mode)
                MODE_MUL: begin
                    any_zero = 1'b0;
                    for (int i = 0; i < n; i++) begin
                        if (v[i] == 0) any_zero = 1'b1;
                    end
                    if (!any_zero) begin
                        neg = v[0] < 0;
                        acc = v[0];
                        mag = (acc < 0) ? -acc : acc;
                        for (int i = 1; i < n; i++) begin
                            acc = v[i];
                            b = (acc < 0) ? -acc : acc;
                            if (acc < 0) neg = !neg;
                            lim = neg ? 64'(NEG_LIM) : 64'(POS_LIM);
                            // Round half away from zero on the magnitude, then clamp.
                            prod = 128'(mag) * 128'(b) + (128'(1) << (FRAC_BITS - 1));
                            prod = prod >> FRAC_BITS;
                            if (prod > 128'(lim)) begin
                                clip = 1'b1;
                                mag = lim;
                            end else begin
                                mag = prod[63:0];
                            end
                        end
                        acc = neg ? -$signed(mag) : $signed(mag);
                    end
                end
                MODE_MAX, MODE_MIN, MODE_RANGE: begin
                    mx = v[0];
                    mn = v[0];
                    for (int i = 1; i < n; i++) begin
                        if (v[i] > mx) mx = v[i];
                        if (v[i] < mn) mn = v[i];
                    end
                    acc = (pm_mode == MODE_MAX) ? mx : (pm_mode == MODE_MIN) ? mn : mx - mn;
                end
                default: begin
                    sum = '0;
                    for (int i = 0; i < n; i++) sum += v[i];
                    m = (sum < 0) ? -sum : sum;
                    q = (m + 64'(n / 2)) / 64'(n);
                    acc = (sum < 0) ? -$signed(q) : $signed(q);
                end
            endcase
        end
        r.combined_value = nod ? '0 : acc[OUT_W-1:0];
        r.is_nodata      = nod;
        r.saturated      = !nod && clip;
        return r;
    endfunction

    // Scoreboard: results are scored at the edge that takes them, cells are
    // predicted at the edge that accepts them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pm_mode  = MODE_MUL;
            pm_lanes = LANES_RESET;
            for (int i = 0; i < LANES; i++) pm_nodata[i] = '0;
        end else begin
            if (o_result_strobe) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0h/%0b/%0b arrived with nothing pending",
                                 o_result.combined_value, o_result.is_nodata,
                                 o_result.saturated);
                end else begin
                    next_due = due_results.pop_front();
                    if (o_result.combined_value !== next_due.combined_value ||
                        o_result.is_nodata !== next_due.is_nodata ||
                        o_result.saturated !== next_due.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: value %h nodata %b sat %b, expected %h %b %b",
                                     results_seen, o_result.combined_value,
                                     o_result.is_nodata, o_result.saturated,
                                     next_due.combined_value, next_due.is_nodata,
                                     next_due.saturated);
                    end
                end
            end
            if (start && !busy) begin
                next_due = pin_on ? pin_want : combine_cells(i_cells);
                nodata_seen += next_due.is_nodata;
                clipped_seen += next_due.saturated;
                due_results.push_back(next_due);
            end
            if (i_cfg_we) begin
                cfg_writes++;
                if (i_cfg_idx == CFG_IDX_W'(REG_MODE))
                    pm_mode = i_cfg_data[MODE_W-1:0];
                else if (i_cfg_idx == CFG_IDX_W'(REG_LANES))
                    pm_lanes = i_cfg_data[LANES_REG_W-1:0];
                else if (int'(i_cfg_idx) >= REG_NODATA0 && int'(i_cfg_idx) < REG_NODATA0 + LANES)
                    pm_nodata[int'(i_cfg_idx) - REG_NODATA0] = i_cfg_data;
            end
        end
    end

    function automatic void add_row(input logic [MODE_W-1:0] mode,
                                    input logic [LANES_REG_W-1:0] lanes,
                                    input logic nd_on,
                                    input t_cells cells,
                                    input logic typed,
                                    input t_result want);
        t_row r;
        r.mode  = mode;
        r.lanes = lanes;
        r.nd_on = nd_on;
        r.cells = cells;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell(input int lane);
        int unsigned      k;
        logic [31:0]      r;
        logic [CELL_W-1:0] mag;
        k = $urandom_range(99);
        r = $urandom;
        if (k < 5) return nodata_now[lane];
        if (k < 35) return r;
        // Small values keep products and means away from the clamp.
        if (k < 60) return {{13{r[18]}}, r[18:0]};
        if (k < 80) begin
            mag = 32'h0000_8000 + r[17:0];
            return r[31] ? -mag : mag;
        end
        case (r[2:0])
            3'd0:    return C_MIN;
            3'd1:    return C_MAX;
            3'd2:    return '0;
            3'd3:    return 32'h0000_0001;
            3'd4:    return C_MONE;
            default: return C_ONE;
        endcase
    endfunction

    task automatic push_cells(input t_cells c, input logic typed, input t_result want);
        while (!calm && $urandom_range(99) < 8) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_cells  <= c;
        pin_on   <= typed;
        pin_want <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cells_sent++;
    endtask

    task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Registers change only once every pending cell has come back.
    task automatic set_config(input logic [MODE_W-1:0] mode,
                              input logic [LANES_REG_W-1:0] lanes,
                              input t_lanes nd);
        start <= 1'b0;
        while (results_seen != cells_sent) @(posedge i_clk);
        write_reg(REG_MODE, CFG_DATA_W'(mode));
        write_reg(REG_LANES, CFG_DATA_W'(lanes));
        for (int i = 0; i < LANES; i++) write_reg(REG_NODATA0 + i, nd[i]);
        i_cfg_we <= 1'b0;
        nodata_now = nd;
    endtask

    initial begin
        logic [MODE_W-1:0]      mode, cur_mode;
        logic [LANES_REG_W-1:0] lanes, cur_lanes;
        logic                   cur_nd_on;
        t_lanes                 nd;

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_cells    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        pin_on     <= 1'b0;
        pin_want   <= '0;
        calm       = 1'b0;
        nodata_now = '0;
        cur_mode   = MODE_MUL;
        cur_lanes  = LANES_RESET;
        cur_nd_on  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first two rows run on the reset register values.
        add_row(MODE_MUL, 3'd4, 1'b0, {C_ONE, C_ONE, C_ONE, C_ONE},
                1'b1, {48'h0000_0001_0000, 1'b0, 1'b0});
        add_row(MODE_MUL, 3'd4, 1'b0, {C_ONE, C_ONE, 32'h0, C_ONE},
                1'b1, {48'h0, 1'b1, 1'b0});
        add_row(MODE_MUL, 3'd4, 1'b1, {32'h0, C_MAX, C_MIN, C_MONE},
                1'b1, {48'h0, 1'b0, 1'b0});
        add_row(MODE_MUL, 3'd4, 1'b1, {C_MAX, C_MAX, C_MAX, C_MAX},
                1'b1, {POS_LIM, 1'b0, 1'b1});
        add_row(MODE_MUL, 3'd4, 1'b1, {C_MIN, C_MIN, C_MIN, C_MIN},
                1'b1, {POS_LIM, 1'b0, 1'b1});
        add_row(MODE_MUL, 3'd3, 1'b1, {C_MIN, C_MIN, C_MIN, C_MIN},
                1'b1, {NEG_LIM, 1'b0, 1'b1});
        add_row(MODE_MUL, 3'd1, 1'b1, {C_MONE, C_MAX, C_MAX, C_MAX},
                1'b1, {48'hFFFF_FFFF_FFFF, 1'b0, 1'b0});
        // Rounding ties on the product, both signs.
        add_row(MODE_MUL, 3'd2, 1'b1, {32'h0000_8000, 32'h1, C_ONE, C_ONE}, 1'b0, '0);
        add_row(MODE_MUL, 3'd2, 1'b1, {32'hFFFF_8000, 32'h1, C_ONE, C_ONE}, 1'b0, '0);
        add_row(MODE_MUL, 3'd4, 1'b1,
                {32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0003_0000}, 1'b0, '0);
        add_row(MODE_MAX, 3'd4, 1'b1, {C_MIN, C_MAX, C_MONE, 32'h5},
                1'b1, {48'h0000_7FFF_FFFF, 1'b0, 1'b0});
        add_row(MODE_MIN, 3'd4, 1'b1, {C_MIN, C_MAX, C_MONE, 32'h5},
                1'b1, {48'hFFFF_8000_0000, 1'b0, 1'b0});
        add_row(MODE_RANGE, 3'd4, 1'b1, {C_MIN, C_MAX, C_MONE, 32'h5},
                1'b1, {48'h0000_FFFF_FFFF, 1'b0, 1'b0});
        add_row(MODE_RANGE, 3'd1, 1'b1, {C_MIN, C_MAX, C_MONE, 32'h5},
                1'b1, {48'h0, 1'b0, 1'b0});
        add_row(MODE_MEAN, 3'd4, 1'b1, {C_MAX, C_MAX, C_MAX, C_MAX},
                1'b1, {48'h0000_7FFF_FFFF, 1'b0, 1'b0});
        add_row(MODE_MEAN, 3'd4, 1'b1, {C_MIN, C_MIN, C_MIN, C_MIN},
                1'b1, {48'hFFFF_8000_0000, 1'b0, 1'b0});
        add_row(MODE_MEAN, 3'd2, 1'b1, {32'h1, 32'h2, C_MIN, C_MIN}, 1'b0, '0);
        add_row(MODE_MEAN, 3'd2, 1'b1, {C_MONE, 32'hFFFF_FFFE, C_MIN, C_MIN}, 1'b0, '0);
        add_row(MODE_MEAN, 3'd3, 1'b1, {C_MONE, C_MONE, 32'h1, C_MIN}, 1'b0, '0);
        // A nodata match counts only on a lane that is in use.
        add_row(MODE_MEAN, 3'd4, 1'b1, {C_ONE, C_ONE, C_ONE, ND_DIR[3]},
                1'b1, {48'h0, 1'b1, 1'b0});
        add_row(MODE_MEAN, 3'd3, 1'b1, {C_ONE, C_ONE, C_ONE, ND_DIR[3]}, 1'b0, '0);
        add_row(MODE_MAX, 3'd0, 1'b1, {C_ONE, C_MAX, C_MIN, C_ONE},
                1'b1, {48'h0, 1'b1, 1'b0});
        add_row(MODE_MAX, 3'd7, 1'b1, {C_ONE, C_MIN, C_MIN, C_MAX}, 1'b0, '0);
        add_row(MODE_UNKNOWN_LO, 3'd4, 1'b1, {C_ONE, C_ONE, C_ONE, C_ONE},
                1'b1, {48'h0, 1'b1, 1'b0});
        add_row(MODE_UNKNOWN_HI, 3'd4, 1'b1, {C_ONE, C_ONE, C_ONE, C_ONE},
                1'b1, {48'h0, 1'b1, 1'b0});

        foreach (plan[i]) begin
            if (plan[i].mode != cur_mode || plan[i].lanes != cur_lanes ||
                plan[i].nd_on != cur_nd_on) begin
                set_config(plan[i].mode, plan[i].lanes, plan[i].nd_on ? ND_DIR : '0);
                cur_mode  = plan[i].mode;
                cur_lanes = plan[i].lanes;
                cur_nd_on = plan[i].nd_on;
            end
            push_cells(plan[i].cells, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            mode = (p < 10) ? MODE_W'(p % 5) : MODE_W'($urandom_range(7));
            if (p == 0)
                lanes = 3'd1;
            else if (p == 1)
                lanes = LANES_REG_W'(LANES);
            else if ($urandom_range(7) == 0)
                lanes = LANES_REG_W'($urandom_range(7));
            else
                lanes = LANES_REG_W'($urandom_range(1, LANES));
            for (int i = 0; i < LANES; i++)
                nd[i] = (p == 2) ? C_MIN : (p == 3) ? C_MAX : CELL_W'($urandom);
            set_config(mode, lanes, nd);
            // One phase streams back to back with no sender gaps.
            calm = (p == 4);
            repeat (PHASE_ITEMS)
                push_cells({pick_cell(0), pick_cell(1), pick_cell(2), pick_cell(3)}, 1'b0, '0);
        end

        start <= 1'b0;
        while (results_seen != cells_sent) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $display("%0d results never arrived", due_results.size());
            mismatches += due_results.size();
        end
        $display("ran %0d cells through %0d register writes over %0d settings",
                 cells_sent, cfg_writes, cfg_writes / (REG_NODATA0 + LANES) + 1);
        $display("%0d cells flagged nodata, %0d clipped; %0d mismatches",
                 nodata_seen, clipped_seen, mismatches);
        if (mismatches == 0) begin
            $display("[multi_raster_cell_combine] OK");
        end else begin
            $display("[multi_raster_cell_combine] ERROR");
        end
        $finish;
    end

endmodule
